// File: rtl/owm_pkg.sv
// Shared types and constants for the one-wire bus master.
package owm_pkg;

  // Number of buses served; commands addressed beyond it are rejected.
  localparam int NUM_PORTS = 4;

  // Mode codes of an input word.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_RESET = 3'd1;
  localparam logic [2:0] MODE_WBYTE = 3'd2;
  localparam logic [2:0] MODE_RBYTE = 3'd3;
  localparam logic [2:0] MODE_WBIT  = 3'd4;
  localparam logic [2:0] MODE_RBIT  = 3'd5;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_REL  = 3'd2;
  localparam logic [2:0] PH_RST_REC  = 3'd3;
  localparam logic [2:0] PH_SLOT_LOW = 3'd4;
  localparam logic [2:0] PH_SLOT_REL = 3'd5;
  localparam logic [2:0] PH_SLOT_REC = 3'd6;

  // Timing in microseconds.
  localparam logic [8:0] T_RST_LOW   = 9'd480;
  localparam logic [8:0] T_RST_REL   = 9'd70;
  localparam logic [8:0] T_RST_REC   = 9'd410;
  localparam logic [8:0] T_SLOT_LOW1 = 9'd6;
  localparam logic [8:0] T_SLOT_REL1 = 9'd64;
  localparam logic [8:0] T_SLOT_LOW0 = 9'd60;
  localparam logic [8:0] T_SLOT_REL0 = 9'd10;
  localparam logic [8:0] T_READ_SAMP = 9'd9;
  localparam logic [8:0] T_READ_REC  = 9'd55;
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  // One input word.
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] port;
    logic [7:0] data;
    logic       line_level;
  } owm_item_t;

  // One result word.
  typedef struct packed {
    logic       drive_low;
    logic [1:0] active_port;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } owm_res_t;

endpackage

// File: rtl/one_wire_bus_master.sv
// Path: a word accepted into the input register passes through the sequencer into the result register.
// Throughput: one word per cycle while the result channel does not stall; the sequencer updates once per word.
// An input register and a result register decouple the two channels.
// Reset (rst_n low, synchronous) empties both registers and returns the bus
// sequencer to idle with all counters, flags and the shift byte cleared.
module one_wire_bus_master import owm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [1:0] in_port,
  input  logic [7:0] in_data,
  input  logic       in_line_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_low,
  output logic [1:0] out_active_port,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_presence,
  output logic [7:0] out_read_value,
  output logic       out_rejected
);

  logic      s1_valid_r;
  owm_item_t s1_item_r;
  logic      out_valid_r;
  owm_res_t  out_res_r;
  owm_res_t  seq_res;
  logic      adv;

  // The input register moves on whenever the result register is free.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{mode: in_mode, port: in_port, data: in_data,
                     line_level: in_line_level};
    end
  end

  owm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_valid_r && adv),
    .item  (s1_item_r),
    .res   (seq_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = out_res_r.drive_low;
  assign out_active_port = out_res_r.active_port;
  assign out_busy_res    = out_res_r.busy_res;
  assign out_done_res    = out_res_r.done_res;
  assign out_presence    = out_res_r.presence;
  assign out_read_value  = out_res_r.read_value;
  assign out_rejected    = out_res_r.rejected;

  // A finishing word never reports the bus as still busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("done word reports busy");

  // A dropped command cannot also finish a sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rejected) |-> !out_res_r.done_res)
    else $error("rejected word reports done");

  // A word held in the input register while the result stalls is kept.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("stalled input word lost");

endmodule

// File: rtl/owm_seq.sv
// Timing sequencer: bus state and the result of one word.
module owm_seq import owm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  owm_item_t item,
  output owm_res_t  res
);

  logic [2:0] phase_r, phase_nxt;
  logic [8:0] cnt_r, cnt_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [1:0] bus_r, bus_nxt;
  logic       pres_r, pres_nxt;

  logic       is_cmd;
  logic       port_bad;
  logic       cmd_write;
  logic       cmd_byte;
  logic       slot_bit;
  logic [8:0] cnt_inc;
  logic [3:0] bit_inc;
  logic       last_slot;
  logic       done;
  logic       rej;
  logic       nxt_read;

  assign is_cmd    = (item.mode >= MODE_RESET) && (item.mode <= MODE_RBIT);
  assign port_bad  = 32'(item.port) >= 32'(NUM_PORTS);
  assign cmd_write = (cmd_r == MODE_WBYTE) || (cmd_r == MODE_WBIT);
  assign cmd_byte  = (cmd_r == MODE_WBYTE) || (cmd_r == MODE_RBYTE);
  assign slot_bit  = shift_r[bit_idx_r[2:0]];
  assign cnt_inc   = cnt_r + 9'd1;
  assign bit_inc   = bit_idx_r + 4'd1;
  assign last_slot = bit_inc >= (cmd_byte ? BYTE_BITS : 4'd1);

  // Next state for the word being consumed.
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    cmd_nxt     = cmd_r;
    bus_nxt     = bus_r;
    pres_nxt    = pres_r;
    done        = 1'b0;
    rej         = 1'b0;
    if (step) begin
      if (is_cmd) begin
        if ((phase_r != PH_IDLE) || port_bad) begin
          rej = 1'b1;
        end else begin
          cmd_nxt     = item.mode;
          bus_nxt     = item.port;
          cnt_nxt     = '0;
          bit_idx_nxt = '0;
          if (item.mode == MODE_RESET) begin
            pres_nxt  = 1'b0;
            shift_nxt = '0;
            phase_nxt = PH_RST_LOW;
          end else begin
            if (item.mode == MODE_WBYTE) begin
              shift_nxt = item.data;
            end else if (item.mode == MODE_WBIT) begin
              shift_nxt = {7'd0, item.data[0]};
            end else begin
              shift_nxt = '0;
            end
            phase_nxt = PH_SLOT_LOW;
          end
        end
      end else if ((item.mode == MODE_TICK) && (phase_r != PH_IDLE)) begin
        cnt_nxt = cnt_inc;
        case (phase_r)
          PH_RST_LOW: begin
            if (cnt_inc >= T_RST_LOW) begin
              phase_nxt = PH_RST_REL;
              cnt_nxt   = '0;
            end
          end
          PH_RST_REL: begin
            if (cnt_inc >= T_RST_REL) begin
              pres_nxt  = ~item.line_level;
              phase_nxt = PH_RST_REC;
              cnt_nxt   = '0;
            end
          end
          PH_RST_REC: begin
            if (cnt_inc >= T_RST_REC) begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              done      = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (cnt_inc >= ((cmd_write && !slot_bit) ? T_SLOT_LOW0 : T_SLOT_LOW1)) begin
              phase_nxt = PH_SLOT_REL;
              cnt_nxt   = '0;
            end
          end
          PH_SLOT_REL: begin
            if (cmd_write) begin
              if (cnt_inc >= (slot_bit ? T_SLOT_REL1 : T_SLOT_REL0)) begin
                bit_idx_nxt = bit_inc;
                cnt_nxt     = '0;
                phase_nxt   = last_slot ? PH_IDLE : PH_SLOT_LOW;
                done        = last_slot;
              end
            end else if (cnt_inc >= T_READ_SAMP) begin
              if (item.line_level) begin
                shift_nxt = shift_r | (8'd1 << bit_idx_r[2:0]);
              end
              phase_nxt = PH_SLOT_REC;
              cnt_nxt   = '0;
            end
          end
          PH_SLOT_REC: begin
            if (cnt_inc >= T_READ_REC) begin
              bit_idx_nxt = bit_inc;
              cnt_nxt     = '0;
              phase_nxt   = last_slot ? PH_IDLE : PH_SLOT_LOW;
              done        = last_slot;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result word seen from the updated state.
  assign nxt_read        = (cmd_nxt == MODE_RBYTE) || (cmd_nxt == MODE_RBIT);
  assign res.drive_low   = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW);
  assign res.active_port = bus_nxt;
  assign res.busy_res    = phase_nxt != PH_IDLE;
  assign res.done_res    = done;
  assign res.presence    = pres_nxt;
  assign res.read_value  = nxt_read ? shift_nxt : 8'd0;
  assign res.rejected    = rej;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      cmd_r     <= '0;
      bus_r     <= '0;
      pres_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      cmd_r     <= cmd_nxt;
      bus_r     <= bus_nxt;
      pres_r    <= pres_nxt;
    end
  end

endmodule
